// File: hdl/vtp_pkg.sv
// Shared types and widths for the vertex transform pipeline.
// No dependencies; every other file imports this package.
package vtp_pkg;

  // coordinate and matrix entry width
  localparam int unsigned COORD_W = 32;
  // exact row sum of three products plus a translation term
  localparam int unsigned SUM_W   = 65;
  // divider numerator and divisor magnitude width
  localparam int unsigned NUM_W   = 65;
  // quotient bits resolved (one above the clamp range)
  localparam int unsigned Q_W     = 33;
  // width that holds a divisor shifted by the top quotient bit
  localparam int unsigned DW      = NUM_W + Q_W;
  localparam int unsigned NREG    = 8;
  localparam int unsigned REG_W   = 64;

  typedef logic [3:0][3:0][COORD_W-1:0] mat_t;

  // one divider lane request
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] dv;
    logic             ovf;
    logic             neg;
    logic             div;
  } lane_req_t;

  // one divider lane result
  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           ovf;
    logic           neg;
    logic           div;
  } lane_res_t;

endpackage

// File: hdl/vtp_mul.sv
// Stage 1: the twelve 32x32 signed products of the matrix with the point.
// Depends on vtp_pkg.
module vtp_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  vtp_pkg::mat_t                    mat,
  input  logic signed [vtp_pkg::COORD_W-1:0] x,
  input  logic signed [vtp_pkg::COORD_W-1:0] y,
  input  logic signed [vtp_pkg::COORD_W-1:0] z,
  output logic                             out_vld,
  output logic [3:0][2:0][2*vtp_pkg::COORD_W-1:0] prod,
  output logic [3:0][vtp_pkg::COORD_W-1:0] tr
);
  import vtp_pkg::*;

  logic signed [COORD_W-1:0] vec [3];

  assign vec[0] = x;
  assign vec[1] = y;
  assign vec[2] = z;

  // hold valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // register products and translation column
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(mat[r][c]) * vec[c];
        end
        tr[r] <= mat[r][3];
      end
    end
  end

endmodule

// File: hdl/vtp_sum.sv
// Stages 2 and 3: row sums, rescale, divide decision and divider setup.
// Depends on vtp_pkg.
module vtp_sum #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_vld,
  input  logic [3:0][2:0][2*vtp_pkg::COORD_W-1:0] prod,
  input  logic [3:0][vtp_pkg::COORD_W-1:0]        tr,
  output logic                                    out_vld,
  output vtp_pkg::lane_req_t [2:0]                req
);
  import vtp_pkg::*;

  localparam int unsigned RES_W = SUM_W - FRAC_BITS;
  localparam logic [RES_W-1:0] ONE = RES_W'(1) << FRAC_BITS;

  logic [3:0][SUM_W-1:0] sum;
  logic                  sum_vld;
  logic signed [RES_W-1:0] res [4];
  logic                  divide;
  logic [NUM_W-1:0]      aw;
  logic [NUM_W-1:0]      av [3];
  lane_req_t [2:0]       req_next;

  // stage 2: exact row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else if (en) begin
      sum_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum[r] <= SUM_W'($signed(prod[r][0])) + SUM_W'($signed(prod[r][1]))
                + SUM_W'($signed(prod[r][2]))
                + (SUM_W'($signed(tr[r])) << FRAC_BITS);
      end
    end
  end

  // stage 3: rescale, magnitudes, overflow pre-check
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      res[r] = RES_W'($signed(sum[r]) >>> FRAC_BITS);
    end
    divide = (res[3] != '0) && (res[3] != ONE);
    aw = res[3][RES_W-1] ? NUM_W'(-res[3]) : NUM_W'(res[3]);
    for (int r = 0; r < 3; r++) begin
      av[r] = res[r][RES_W-1] ? NUM_W'(-res[r]) : NUM_W'(res[r]);
      req_next[r].div = divide;
      req_next[r].num = divide ? (av[r] << FRAC_BITS) : av[r];
      req_next[r].dv  = divide ? aw : NUM_W'(1);
      req_next[r].neg = divide ? (res[r][RES_W-1] ^ res[3][RES_W-1]) : res[r][RES_W-1];
      req_next[r].ovf = DW'(req_next[r].num) >= (DW'(req_next[r].dv) << Q_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req <= req_next;
    end
  end

endmodule

// File: hdl/vtp_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on vtp_pkg.
module vtp_div_lane (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  vtp_pkg::lane_req_t req,
  output logic               out_vld,
  output vtp_pkg::lane_res_t res
);
  import vtp_pkg::*;

  logic                  vld [Q_W+1];
  logic [NUM_W-1:0]      rem [Q_W+1];
  logic [NUM_W-1:0]      dv  [Q_W+1];
  logic [Q_W-1:0]        q   [Q_W+1];
  logic                  ovf [Q_W+1];
  logic                  neg [Q_W+1];
  logic                  div [Q_W+1];

  assign vld[0] = in_vld;
  assign rem[0] = req.num;
  assign dv[0]  = req.dv;
  assign q[0]   = '0;
  assign ovf[0] = req.ovf;
  assign neg[0] = req.neg;
  assign div[0] = req.div;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned B = Q_W - 1 - k;
    logic [DW-1:0] shd;
    logic          ge;

    // try to subtract the divisor shifted to this quotient bit
    assign shd = DW'(dv[k]) << B;
    assign ge  = DW'(rem[k]) >= shd;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? (rem[k] - shd[NUM_W-1:0]) : rem[k];
        q[k+1]   <= q[k] | (Q_W'(ge) << B);
        dv[k+1]  <= dv[k];
        ovf[k+1] <= ovf[k];
        neg[k+1] <= neg[k];
        div[k+1] <= div[k];
      end
    end
  end

  assign out_vld = vld[Q_W];
  assign res.q   = q[Q_W];
  assign res.ovf = ovf[Q_W];
  assign res.neg = neg[Q_W];
  assign res.div = div[Q_W];

endmodule

// File: hdl/vertex_transform_perspective_top.sv
// Top level: matrix registers, pipeline stages and the saturating output register.
// Depends on vtp_pkg, vtp_mul, vtp_sum and vtp_div_lane.

// Transforms one Q(32-FRAC_BITS).FRAC_BITS point (x,y,z,1) by the 4x4 matrix in
// the eight configuration registers (identity after reset), divides x, y and z by
// w when w is neither zero nor 1.0, and saturates each to 32 bits. One request is
// accepted every cycle while the output is not stalled; a result passes through one
// multiply stage, one row-sum stage, one divider setup stage, 33 divider stages (one
// quotient bit each) and the output register. When the output is stalled the whole pipeline
// holds. Write the matrix only while the pipeline is empty.
module vertex_transform_perspective_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [vtp_pkg::REG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [vtp_pkg::COORD_W-1:0]  x_in,
  input  logic signed [vtp_pkg::COORD_W-1:0]  y_in,
  input  logic signed [vtp_pkg::COORD_W-1:0]  z_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vtp_pkg::COORD_W-1:0]  x_out,
  output logic signed [vtp_pkg::COORD_W-1:0]  y_out,
  output logic signed [vtp_pkg::COORD_W-1:0]  z_out,
  output logic                                divide_applied,
  output logic                                saturated
);
  import vtp_pkg::*;

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_HI = ONE_LO << COORD_W;

  logic [REG_W-1:0]                  cfg [NREG];
  mat_t                              mat;
  logic                              adv;
  logic                              s1_vld;
  logic [3:0][2:0][2*COORD_W-1:0]    prod;
  logic [3:0][COORD_W-1:0]           tr;
  logic                              s3_vld;
  lane_req_t [2:0]                   req;
  logic [2:0]                        lane_vld;
  lane_res_t                         lres [3];
  logic [COORD_W-1:0]                val_next [3];
  logic [2:0]                        sat_next;

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[0] <= ONE_LO;
      cfg[1] <= '0;
      cfg[2] <= ONE_HI;
      cfg[3] <= '0;
      cfg[4] <= '0;
      cfg[5] <= ONE_LO;
      cfg[6] <= '0;
      cfg[7] <= ONE_HI;
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // unpack two entries per register
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = cfg[2*r][COORD_W-1:0];
      mat[r][1] = cfg[2*r][REG_W-1:COORD_W];
      mat[r][2] = cfg[2*r+1][COORD_W-1:0];
      mat[r][3] = cfg[2*r+1][REG_W-1:COORD_W];
    end
  end

  // advance everything unless the output holds an untaken result
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  vtp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (in_valid),
    .mat     (mat),
    .x       (x_in),
    .y       (y_in),
    .z       (z_in),
    .out_vld (s1_vld),
    .prod    (prod),
    .tr      (tr)
  );

  vtp_sum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (s1_vld),
    .prod    (prod),
    .tr      (tr),
    .out_vld (s3_vld),
    .req     (req)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vtp_div_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .in_vld  (s3_vld),
      .req     (req[i]),
      .out_vld (lane_vld[i]),
      .res     (lres[i])
    );
  end

  // clamp each quotient to the signed 32-bit range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic neg_eff;
      logic over;
      neg_eff = lres[i].neg && (lres[i].ovf || (lres[i].q != '0));
      over    = lres[i].ovf ||
                (neg_eff ? (lres[i].q > Q_W'(33'h080000000))
                         : (lres[i].q > Q_W'(33'h07fffffff)));
      sat_next[i] = over;
      if (over) begin
        val_next[i] = neg_eff ? 32'h80000000 : 32'h7fffffff;
      end else if (neg_eff) begin
        val_next[i] = -lres[i].q[COORD_W-1:0];
      end else begin
        val_next[i] = lres[i].q[COORD_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= lane_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_out          <= val_next[0];
      y_out          <= val_next[1];
      z_out          <= val_next[2];
      divide_applied <= lres[0].div;
      saturated      <= |sat_next;
    end
  end

`ifndef SYNTHESIS
  // the three divider lanes always present valid results in step
  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    ($countones(lane_vld) == 0) || ($countones(lane_vld) == 3))
    else $error("divider lanes out of step");

  // the output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // a stalled result is never dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(x_out) && $stable(saturated)))
    else $error("stalled result lost");
`endif

endmodule

// File: sim/tb.sv
// Testbench for vertex_transform_perspective_top: directed and random points
// checked against a bit-accurate transform and divide predictor. Depends on vtp_pkg.
`timescale 1ns / 1ps

module tb;
  import vtp_pkg::*;

  localparam int FRAC      = 16;
  localparam int LATENCY   = 37;
  localparam int CYC_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               div;
    logic               sat;
  } point_res_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [2:0]                cfg_index = '0;
  logic [REG_W-1:0]          cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] x_in = '0;
  logic signed [COORD_W-1:0] y_in = '0;
  logic signed [COORD_W-1:0] z_in = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] x_out;
  logic signed [COORD_W-1:0] y_out;
  logic signed [COORD_W-1:0] z_out;
  logic                      divide_applied;
  logic                      saturated;

  // predictor copy of the matrix registers
  logic [REG_W-1:0] mat_regs [NREG];
  point_res_t       expected_pts [$];
  int               mismatches = 0;
  int               cycles = 0;
  int               points_sent = 0;
  int               points_checked = 0;
  int               divided_seen = 0;
  int               saturated_seen = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               recv_hold = 0;

  vertex_transform_perspective_top #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .x_in(x_in), .y_in(y_in), .z_in(z_in),
    .out_valid(out_valid), .out_ready(out_ready), .x_out(x_out), .y_out(y_out),
    .z_out(z_out), .divide_applied(divide_applied), .saturated(saturated)
  );

  always #5 clk = ~clk;

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // clamp a sign/magnitude value to 32 bits
  function automatic logic [31:0] clamp_coord(input logic neg, input logic [127:0] mag,
                                              inout logic sat);
    logic [127:0] lim;
    logic [127:0] m;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    m = mag;
    if (m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? 32'(-m) : 32'(m);
  endfunction

  // matrix times (x,y,z,1), rescale, optional divide by w, saturate
  function automatic point_res_t transform_point(input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input logic signed [31:0] pz);
    logic signed [127:0] vec [4];
    logic signed [127:0] rows [4];
    logic signed [127:0] acc;
    logic signed [127:0] ent;
    logic signed [31:0]  e32;
    logic [127:0]        av;
    logic [127:0]        aw;
    logic [127:0]        q;
    logic [31:0]         outs [3];
    logic                neg;
    logic                sat;
    logic                div;
    point_res_t          r;
    vec[0] = px;
    vec[1] = py;
    vec[2] = pz;
    vec[3] = 128'sd1 <<< FRAC;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        e32 = (c & 1) ? mat_regs[i*2 + c/2][63:32] : mat_regs[i*2 + c/2][31:0];
        ent = e32;
        acc = acc + ent * vec[c];
      end
      rows[i] = acc >>> FRAC;
    end
    sat = 1'b0;
    div = (rows[3] != 0) && (rows[3] != (128'sd1 <<< FRAC));
    for (int i = 0; i < 3; i++) begin
      av = rows[i] < 0 ? -rows[i] : rows[i];
      if (div) begin
        aw = rows[3] < 0 ? -rows[3] : rows[3];
        q = (av << FRAC) / aw;
        neg = ((rows[i] < 0) != (rows[3] < 0)) && (q != 0);
        outs[i] = clamp_coord(neg, q, sat);
      end else begin
        outs[i] = clamp_coord(rows[i] < 0, av, sat);
      end
    end
    r.x = outs[0];
    r.y = outs[1];
    r.z = outs[2];
    r.div = div;
    r.sat = sat;
    return r;
  endfunction

  // receiver: random back-pressure plus long holds on request
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    point_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%h y=%h z=%h", x_out, y_out, z_out);
      end else begin
        e = expected_pts.pop_front();
        points_checked++;
        if (divide_applied) divided_seen++;
        if (saturated) saturated_seen++;
        if (x_out !== e.x || y_out !== e.y || z_out !== e.z ||
            divide_applied !== e.div || saturated !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h div=%b sat=%b got %h %h %h div=%b sat=%b",
                     e.x, e.y, e.z, e.div, e.sat,
                     x_out, y_out, z_out, divide_applied, saturated);
        end
      end
    end
  end

  // offer one request and hold it until accepted
  task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    x_in = px;
    y_in = py;
    z_in = pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pts.push_back(transform_point(px, py, pz));
    points_sent++;
    @(negedge clk);
  endtask

  // wait for every result, then let the pipeline empty
  task automatic drain();
    in_valid = 1'b0;
    while (expected_pts.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [63:0] val);
    cfg_we = 1'b1;
    cfg_index = idx[2:0];
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    mat_regs[idx] = val;
  endtask

  task automatic load_identity();
    write_reg(0, 64'h0000_0000_0001_0000);
    write_reg(1, 64'h0);
    write_reg(2, 64'h0001_0000_0000_0000);
    write_reg(3, 64'h0);
    write_reg(4, 64'h0);
    write_reg(5, 64'h0000_0000_0001_0000);
    write_reg(6, 64'h0);
    write_reg(7, 64'h0001_0000_0000_0000);
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return 32'h0;
      2:       return 32'h0001_0000;
      3:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0, 1:    return $urandom();
      2:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(16777215)) - 8388608);
    endcase
  endfunction

  // random matrix from mixed random entries, or from all-ones and fully random registers
  task automatic load_random_matrix(input bit extremes);
    logic [63:0] v;
    for (int i = 0; i < NREG; i++) begin
      if (extremes)
        v = $urandom_range(1) ? 64'hffff_ffff_ffff_ffff : {$urandom(), $urandom()};
      else
        v = {rand_entry(), rand_entry()};
      write_reg(i, v);
    end
  endtask

  // pass-through of field extremes, rounding, w zero, w one, divide overflow
  task automatic test_directed();
    logic [31:0] ext [6];
    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'h5555_aaaa};
    for (int i = 0; i < 6; i++) send_point(ext[i], ext[(i+1)%6], ext[(i+2)%6]);
    drain();
    // half scale on x: odd negative values round toward minus infinity
    write_reg(0, 64'h0000_0000_0000_8000);
    send_point(32'hffff_ffff, 32'h1, 32'h3);
    send_point(32'h8000_0001, 32'h7fff_ffff, 32'h0);
    drain();
    // large translation saturates x
    write_reg(1, 64'h7fff_ffff_0000_0000);
    send_point(32'h7fff_ffff, 32'h0, 32'h0);
    drain();
    // w forced to zero: no divide
    write_reg(6, 64'h0);
    write_reg(7, 64'h0);
    send_point(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff);
    drain();
    // w = 2.0 and -0.5: normal divides
    write_reg(7, 64'h0002_0000_0000_0000);
    send_point(32'h0003_0000, 32'hfffd_0000, 32'h0000_0001);
    drain();
    write_reg(7, 64'hffff_8000_0000_0000);
    send_point(32'h0003_0000, 32'hfffd_0000, 32'h0);
    drain();
    // tiny w: quotient overflows and clamps
    write_reg(7, 64'h0000_0001_0000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    drain();
    // w from z with negative sign
    write_reg(7, 64'h0);
    write_reg(6, 64'h0);
    write_reg(7, 64'h0000_0000_ffff_0000);
    send_point(32'h0010_0000, 32'h0, 32'h0002_0000);
    send_point(32'h0010_0000, 32'h0, 32'h0);
    drain();
    load_identity();
  endtask

  // random points across several matrices under one idling mix
  task automatic test_random(input int n_points, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int k = 0; k < n_points; k++) begin
      if (k % 160 == 0) begin
        drain();
        if ((k / 160) % 5 == 4) load_random_matrix(1'b1);
        else if ((k / 160) % 5 == 3) load_identity();
        else load_random_matrix(1'b0);
      end
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    drain();
  endtask

  // long receiver hold so the pipeline fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random_matrix(1'b0);
    recv_hold = 300;
    for (int k = 0; k < 80; k++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  initial begin
    for (int i = 0; i < NREG; i++) mat_regs[i] = '0;
    mat_regs[0] = 64'h0000_0000_0001_0000;
    mat_regs[2] = 64'h0001_0000_0000_0000;
    mat_regs[5] = 64'h0000_0000_0001_0000;
    mat_regs[7] = 64'h0001_0000_0000_0000;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(640, 22, 75);
    test_random(640, 75, 22);
    test_backpressure();
    test_random(640, 0, 0);
    drain();
    $display("checked %0d of %0d points, %0d with divide, %0d saturated",
             points_checked, points_sent, divided_seen, saturated_seen);
    if (mismatches == 0 && expected_pts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_pts.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
